FILE: src/lrct_pkg.sv
`timescale 1ns / 1ps
package lrct_pkg;

    localparam int ENTRIES    = 20;
    localparam int STD_COLORS = 20;
    localparam int COLOR_W    = 24;
    localparam int IDX_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int RANK_W     = $clog2(ENTRIES + 1);
    localparam int CNT_W      = $clog2(ENTRIES);

    localparam logic OP_PICK   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd2;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [RANK_W-1:0]  rank;
    } entry_t;

    function automatic logic [COLOR_W-1:0] std_color(input int i);
        logic [COLOR_W-1:0] c;
        unique case (i % STD_COLORS)
            0:       c = 24'h000000;
            1:       c = 24'h000080;
            2:       c = 24'h008000;
            3:       c = 24'h008080;
            4:       c = 24'h800000;
            5:       c = 24'h800080;
            6:       c = 24'h808000;
            7:       c = 24'hC0C0C0;
            8:       c = 24'hC0DCC0;
            9:       c = 24'hF0CAA6;
            10:      c = 24'hF0FBFF;
            11:      c = 24'hA4A0A0;
            12:      c = 24'h808080;
            13:      c = 24'h0000FF;
            14:      c = 24'h00FF00;
            15:      c = 24'h00FFFF;
            16:      c = 24'hFF0000;
            17:      c = 24'hFF00FF;
            18:      c = 24'hFFFF00;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

    function automatic logic [RANK_W-1:0] init_rank(input int i);
        logic [RANK_W-1:0] r;
        if (i < (ENTRIES + 1) / 2) begin
            r = RANK_W'(2 * i + 1);
        end else begin
            r = RANK_W'(2 * (ENTRIES - i));
        end
        return r;
    endfunction

endpackage

FILE: src/lrct_cell.sv
`timescale 1ns / 1ps
module lrct_cell
    import lrct_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   shift_en,
    input  entry_t init_val,
    input  entry_t d,
    output entry_t q
);

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= init_val;
        end else if (shift_en) begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

FILE: src/lru_ranked_color_table.sv
`timescale 1ns / 1ps
// Twenty-entry colour table with recency ranks, held in a ring of cells that
// rotates one place per cycle past a single compare point while a pick or
// search is worked on. Such a request takes two full turns of the ring: one
// to find the match or victim, one to write back the promoted ranks and any
// new colour; a bad index is answered without turning the ring. One request
// is worked on at a time; a finished result waits in the output register
// while the next request is taken.
module lru_ranked_color_table
    import lrct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [4:0] entry_index, [28:5] search_color
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [4:0] picked_index, [28:5] picked_color,
                                   // [30:29] status
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_HOLD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic                hit_reg, hit_next;
    logic [CNT_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [RANK_W-1:0]   hit_rank_reg, hit_rank_next;
    logic [CNT_W-1:0]    vic_idx_reg, vic_idx_next;
    logic [CNT_W-1:0]    sel_idx_reg, sel_idx_next;
    logic [RANK_W-1:0]   sel_rank_reg, sel_rank_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [COLOR_W-1:0]  res_color_reg, res_color_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [31:0]         m_tdata_reg, m_tdata_next;

    entry_t ring_q [ENTRIES];
    entry_t ring_d [ENTRIES];
    entry_t head_new;
    logic   shift_en;
    logic   last;
    logic   match;
    logic   in_bad;

    assign shift_en = (state_reg == S_SCAN) || (state_reg == S_UPDATE);
    assign last     = (cnt_reg == CNT_W'(ENTRIES - 1));

    for (genvar k = 0; k < ENTRIES; k++) begin : g_ring
        entry_t init_val;
        assign init_val.color = std_color(k);
        assign init_val.rank  = init_rank(k);
        if (k < ENTRIES - 1) begin : g_mid
            assign ring_d[k] = ring_q[k + 1];
        end else begin : g_tail
            assign ring_d[k] = head_new;
        end
        lrct_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .init_val (init_val),
            .d        (ring_d[k]),
            .q        (ring_q[k])
        );
    end

    assign match = (op_reg == OP_SEARCH) ? (ring_q[0].color == color_reg)
                                         : (IDX_W'(cnt_reg) == idx_reg);
    assign in_bad = (s_tuser[0] == OP_PICK) &&
                    ({1'b0, s_tdata[4:0]} >= (IDX_W + 1)'(ENTRIES));

    always_comb begin
        head_new = ring_q[0];
        if (state_reg == S_UPDATE) begin
            if (cnt_reg == sel_idx_reg) begin
                head_new.rank = RANK_W'(1);
                if (res_status_reg == ST_INSERT) begin
                    head_new.color = color_reg;
                end
            end else if (ring_q[0].rank < sel_rank_reg) begin
                head_new.rank = ring_q[0].rank + RANK_W'(1);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        color_next      = color_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        vic_idx_next    = vic_idx_reg;
        sel_idx_next    = sel_idx_reg;
        sel_rank_next   = sel_rank_reg;
        res_idx_next    = res_idx_reg;
        res_color_next  = res_color_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[0];
                    idx_next   = s_tdata[4:0];
                    color_next = s_tdata[28:5];
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    if (in_bad) begin
                        res_idx_next    = '0;
                        res_color_next  = '0;
                        res_status_next = ST_BAD_IDX;
                        state_next      = S_HOLD;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (match && !hit_reg) begin
                    hit_next      = 1'b1;
                    hit_idx_next  = cnt_reg;
                    hit_rank_next = ring_q[0].rank;
                end
                if (ring_q[0].rank == RANK_W'(ENTRIES)) begin
                    vic_idx_next = cnt_reg;
                end
                if (last) begin
                    cnt_next = '0;
                    if (hit_next) begin
                        sel_idx_next    = hit_idx_next;
                        sel_rank_next   = hit_rank_next;
                        res_status_next = ST_HIT;
                    end else begin
                        sel_idx_next    = vic_idx_next;
                        sel_rank_next   = RANK_W'(ENTRIES);
                        res_status_next = ST_INSERT;
                    end
                    state_next = S_UPDATE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_UPDATE: begin
                if (cnt_reg == sel_idx_reg) begin
                    res_idx_next   = IDX_W'(cnt_reg);
                    res_color_next = head_new.color;
                end
                if (last) begin
                    cnt_next   = '0;
                    state_next = S_HOLD;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_status_reg, res_color_reg, res_idx_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            hit_reg      <= hit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        color_reg      <= color_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        vic_idx_reg    <= vic_idx_next;
        sel_idx_reg    <= sel_idx_next;
        sel_rank_reg   <= sel_rank_next;
        res_idx_reg    <= res_idx_next;
        res_color_reg  <= res_color_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_scan_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) && last |=> (state_reg == S_UPDATE))
        else $error("scan pass did not hand over to update pass");

    a_head_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_q[0].rank != '0) && (ring_q[0].rank <= RANK_W'(ENTRIES)))
        else $error("rank at ring head out of range");

    a_update_to_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPDATE) && last |=> (state_reg == S_HOLD)
        && (res_status_reg != ST_BAD_IDX))
        else $error("update pass ended without a valid result");

    a_cnt_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (cnt_reg == '0))
        else $error("ring not realigned when idle");
`endif

endmodule
